>>> src/ucd_pkg.sv
// Shared types and constants for the undirected cycle detector.
package ucd_pkg;

    // Configuration port geometry
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 5;
    localparam int VERTEX_W        = 4;
    localparam int REG_INDEX_LSB   = 2;
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_edge;
        logic start_search;
        logic root_advance;
        logic root_push;
        logic dfs_step;
        logic set_cycle;
        logic emit_result;
    } ucd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic stack_empty;
        logic root_done;
        logic root_visited;
        logic cycle_hit;
        logic out_free;
    } ucd_status_t;

endpackage

>>> src/ucd_ctrl.sv
// Sequencing state machine for edge load, search and result hand-off.
module ucd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_edge,
    output logic                 in_stall,
    input  ucd_pkg::ucd_status_t status,
    output ucd_pkg::ucd_cmd_t    cmd
);
    import ucd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROOT   = 4'b0010,
        ST_STEP   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take edges only while idle
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_edge = 1'b1;
                    if (last_edge)
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                priority if (status.root_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.root_visited)
                begin
                    cmd.root_advance = 1'b1;
                end
                else
                begin
                    cmd.root_push = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.stack_empty)
                begin
                    state_next = ST_ROOT;
                end
                else
                begin
                    cmd.dfs_step = 1'b1;
                    if (status.cycle_hit)
                    begin
                        cmd.set_cycle = 1'b1;
                        state_next    = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/ucd_datapath.sv
// Adjacency matrix, visited marks, search stack and result register.
module ucd_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ucd_pkg::ucd_cmd_t                     cmd,
    output ucd_pkg::ucd_status_t                  status,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     limit,
    input  logic [ucd_pkg::VERTEX_W-1:0]          src_vertex,
    input  logic [ucd_pkg::VERTEX_W-1:0]          dst_vertex,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  has_cycle,
    output logic                                  edge_ignored
);
    import ucd_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] parent;
        logic          has_parent;
        logic [CW-1:0] scan;
    } entry_t;

    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;
    entry_t                  stack_reg [MAX_VERTICES];
    logic [CW-1:0]           depth_reg;
    logic [CW-1:0]           root_reg;
    logic                    ignored_reg;
    logic                    cycle_reg;
    logic                    out_valid_reg;
    logic                    has_cycle_reg;
    logic                    edge_ignored_reg;

    logic                    edge_ok;
    logic [VW-1:0]           src_idx;
    logic [VW-1:0]           dst_idx;
    logic [VW-1:0]           root_idx;
    logic [VW-1:0]           top_idx;
    logic [VW-1:0]           push_idx;
    entry_t                  top;
    logic [MAX_VERTICES-1:0] cand;
    logic                    have_nb;
    logic [VW-1:0]           nb;
    entry_t                  push_entry;
    entry_t                  top_upd;

    assign edge_ok  = (int'(src_vertex) < int'(limit)) && (int'(dst_vertex) < int'(limit));
    assign src_idx  = VW'(src_vertex);
    assign dst_idx  = VW'(dst_vertex);
    assign root_idx = root_reg[VW-1:0];
    assign top_idx  = VW'(depth_reg - CW'(1));
    assign push_idx = depth_reg[VW-1:0];
    assign top      = stack_reg[top_idx];

    // Pick the lowest unscanned neighbor of the top vertex below the limit
    always_comb
    begin
        logic [MAX_VERTICES-1:0] row;
        row     = adj_reg[top.vertex];
        have_nb = 1'b0;
        nb      = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            cand[i] = row[i] && (CW'(i) < limit) && (CW'(i) >= top.scan);
        end
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                have_nb = 1'b1;
                nb      = VW'(i);
            end
        end
    end

    // Build the pushed child and the updated top entry
    always_comb
    begin
        push_entry.vertex     = nb;
        push_entry.parent     = top.vertex;
        push_entry.has_parent = 1'b1;
        push_entry.scan       = '0;
        top_upd               = top;
        top_upd.scan          = CW'(nb) + CW'(1);
    end

    // Status toward the controller
    assign status.stack_empty  = (depth_reg == '0);
    assign status.root_done    = (root_reg >= limit);
    assign status.root_visited = visited_reg[root_idx];
    assign status.cycle_hit    = (depth_reg != '0) && have_nb && visited_reg[nb]
                                 && (!top.has_parent || (nb != top.parent));
    assign status.out_free     = !out_valid_reg || !out_stall;

    // Adjacency matrix: set both bits per valid edge, clear on result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else if (cmd.emit_result)
        begin
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else if (cmd.load_edge && edge_ok)
        begin
            adj_reg[src_idx][dst_idx] <= 1'b1;
            adj_reg[dst_idx][src_idx] <= 1'b1;
        end
    end

    // Search control state: visited marks, stack depth, root, flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            depth_reg   <= '0;
            root_reg    <= '0;
            ignored_reg <= 1'b0;
            cycle_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_edge && !edge_ok)
            begin
                ignored_reg <= 1'b1;
            end
            if (cmd.emit_result)
            begin
                ignored_reg <= 1'b0;
            end
            if (cmd.start_search)
            begin
                visited_reg <= '0;
                depth_reg   <= '0;
                root_reg    <= '0;
                cycle_reg   <= 1'b0;
            end
            if (cmd.root_advance)
            begin
                root_reg <= root_reg + CW'(1);
            end
            if (cmd.root_push)
            begin
                visited_reg[root_idx] <= 1'b1;
                depth_reg             <= CW'(1);
            end
            if (cmd.dfs_step)
            begin
                if (!have_nb)
                begin
                    depth_reg <= depth_reg - CW'(1);
                end
                else if (!visited_reg[nb])
                begin
                    visited_reg[nb] <= 1'b1;
                    depth_reg       <= depth_reg + CW'(1);
                end
            end
            if (cmd.set_cycle)
            begin
                cycle_reg <= 1'b1;
            end
        end
    end

    // Stack entries: written before read, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.root_push)
        begin
            stack_reg[0].vertex     <= root_idx;
            stack_reg[0].parent     <= '0;
            stack_reg[0].has_parent <= 1'b0;
            stack_reg[0].scan       <= '0;
        end
        if (cmd.dfs_step && have_nb)
        begin
            stack_reg[top_idx] <= top_upd;
            if (!visited_reg[nb])
            begin
                stack_reg[push_idx] <= push_entry;
            end
        end
    end

    // Result register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_result)
        begin
            has_cycle_reg    <= cycle_reg;
            edge_ignored_reg <= ignored_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign has_cycle    = has_cycle_reg;
    assign edge_ignored = edge_ignored_reg;

endmodule

>>> src/undirected_cycle_detect_top.sv
// Edge load: one edge transfer per cycle while idle; in_stall is high from the search until the result is emitted.
// Search: starts the cycle after the last edge; it steps through root checks and stack
//   pushes, pops and neighbor hits, and a cycle found early ends it sooner. out_valid rises
//   when the finish state, once the output is free, emits the result into the output register.
// Result: held in an output register; the next graph loads while it waits.
// Reset (async, active low): vertex_count = 16, matrix, flags and stack depth cleared.
module undirected_cycle_detect_top #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ucd_pkg::ADDR_W-1:0]     paddr,
    input  logic [ucd_pkg::DATA_W-1:0]     pwdata,
    output logic [ucd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ucd_pkg::VERTEX_W-1:0]   src_vertex,
    input  logic [ucd_pkg::VERTEX_W-1:0]   dst_vertex,
    input  logic                           last_edge,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           has_cycle,
    output logic                           edge_ignored
);
    import ucd_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [COUNT_W-1:0] vertex_count_reg;
    logic [CW-1:0]      limit;
    logic               reg_sel;
    ucd_cmd_t           cmd;
    ucd_status_t        status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[REG_INDEX_LSB] == REG_VERTEX_COUNT);

    // Write the vertex count on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            vertex_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Read back the register
    assign prdata = reg_sel ? DATA_W'(vertex_count_reg) : '0;

    // Clamp the count to the matrix size
    assign limit = (int'(vertex_count_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                           : CW'(vertex_count_reg);

    ucd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ucd_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .limit        (limit),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_cycle    (has_cycle),
        .edge_ignored (edge_ignored)
    );

endmodule
